// ===== design/gis_pkg.sv =====
// Shared types and constants for the growable indexed stack unit.
package gis_pkg;

  localparam int SIZE_W    = 11;
  localparam int ITEM_W    = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic [SIZE_W-1:0] INITIAL_SIZE_RST = SIZE_W'(16);
  localparam logic [SIZE_W-1:0] BLOCK_SIZE_RST   = SIZE_W'(16);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INITIAL_SIZE = 1'b0,
    REG_BLOCK_SIZE   = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    FN_PUSH = 2'd0,
    FN_POP  = 2'd1,
    FN_GET  = 2'd2,
    FN_SET  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_OVERFLOW    = 3'd1,
    ST_UNDERFLOW   = 3'd2,
    ST_WRONG_INDEX = 3'd3,
    ST_NO_ROOM     = 3'd4,
    ST_NOT_INIT    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DONE
  } state_t;

  typedef struct packed {
    func_t                     func;
    logic [SIZE_W-1:0]         index;
    logic signed [ITEM_W-1:0]  item_value;
  } in_t;

  typedef struct packed {
    status_t                   status;
    logic signed [ITEM_W-1:0]  item_out;
    logic [SIZE_W-1:0]         item_count;
    logic [SIZE_W-1:0]         capacity;
  } out_t;

endpackage

// ===== design/gis_ram.sv =====
// Single-port-write, single-port-read item memory with registered read data.
module gis_ram #(
  parameter int DEPTH = 1024
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [$clog2(DEPTH)-1:0]          waddr,
  input  logic [gis_pkg::ITEM_W-1:0]        wdata,
  input  logic                              re,
  input  logic [$clog2(DEPTH)-1:0]          raddr,
  output logic [gis_pkg::ITEM_W-1:0]        rdata
);

  logic [gis_pkg::ITEM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/growable_indexed_stack_unit.sv =====
// Top level of the growable indexed stack unit: control, counters and item memory.
//
//   channel   direction  handshake            payload
//   cfg       in         cfg_we               cfg_index, cfg_data
//   in        in         in_valid / in_stall  in_data (gis_pkg::in_t)
//   out       out        out_valid / out_stall out_data (gis_pkg::out_t)
//
// Push, set and failed operations pass from accept through the pending register and the
// done state into the output register; successful pop and get first pass a read state
// for the registered read of the item memory.
// One item is in flight at a time; the next is taken once the result has moved
// into the output register. A stalled result holds the block in its done state.
// Reset sets both size registers to 16, count to 0 and capacity to 16; memory
// contents stay undefined and are only read below count.
module growable_indexed_stack_unit #(
  parameter int DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [gis_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gis_pkg::SIZE_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  gis_pkg::in_t                        in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output gis_pkg::out_t                       out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = ($clog2(DEPTH + 1) > gis_pkg::SIZE_W) ?
                      $clog2(DEPTH + 1) : gis_pkg::SIZE_W;

  logic [gis_pkg::SIZE_W-1:0] init_size;
  logic [gis_pkg::SIZE_W-1:0] blk_size;
  logic [CW-1:0]              count;
  logic [CW-1:0]              cap;

  gis_pkg::state_t state, state_next;
  gis_pkg::out_t   pend;
  logic            accept;
  logic            out_load;

  // operation decode
  gis_pkg::status_t  op_status;
  logic [CW-1:0]     count_next;
  logic [CW-1:0]     cap_next;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [gis_pkg::ITEM_W-1:0] mem_rdata;

  logic [CW:0]       grow_sum;
  logic [CW+1:0]     shrink_sum;
  logic [CW-1:0]     blk_x;
  logic [CW-1:0]     idx_x;
  logic              bad_idx;

  assign blk_x      = CW'(blk_size);
  assign idx_x      = CW'(in_data.index);
  assign grow_sum   = {1'b0, cap} + (CW+1)'(blk_x);
  assign shrink_sum = (CW+2)'(count) + ((CW+2)'(blk_x) << 1);
  assign bad_idx    = (idx_x == '0) || (idx_x > count);

  always_comb begin
    op_status  = gis_pkg::ST_OK;
    count_next = count;
    cap_next   = cap;
    mem_we     = 1'b0;
    mem_waddr  = AW'(count);
    mem_re     = 1'b0;
    mem_raddr  = AW'(count - CW'(1));
    if (init_size == '0 && blk_size == '0) begin
      op_status = gis_pkg::ST_NOT_INIT;
    end else begin
      case (in_data.func)
        gis_pkg::FN_PUSH: begin
          if (count == cap) begin
            if (blk_size == '0) begin
              op_status = gis_pkg::ST_OVERFLOW;
            end else if (grow_sum > (CW+1)'(DEPTH)) begin
              op_status = gis_pkg::ST_NO_ROOM;
            end else begin
              cap_next = grow_sum[CW-1:0];
            end
          end
          if (op_status == gis_pkg::ST_OK && count >= CW'(DEPTH)) begin
            op_status = gis_pkg::ST_NO_ROOM;
          end
          if (op_status == gis_pkg::ST_OK) begin
            mem_we     = 1'b1;
            count_next = count + CW'(1);
          end
        end
        gis_pkg::FN_POP: begin
          if (count == '0) begin
            op_status = gis_pkg::ST_UNDERFLOW;
          end else begin
            if (cap > CW'(init_size) && shrink_sum <= (CW+2)'(cap)) begin
              cap_next = cap - blk_x;
            end
            mem_re     = 1'b1;
            count_next = count - CW'(1);
          end
        end
        default: begin
          // get and set share the index check
          mem_waddr = AW'(idx_x - CW'(1));
          mem_raddr = AW'(idx_x - CW'(1));
          if (bad_idx) begin
            op_status = gis_pkg::ST_WRONG_INDEX;
          end else if (in_data.func == gis_pkg::FN_GET) begin
            mem_re = 1'b1;
          end else begin
            mem_we = 1'b1;
          end
        end
      endcase
    end
  end

  gis_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (accept & mem_we),
    .waddr (mem_waddr),
    .wdata (in_data.item_value),
    .re    (accept & mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // control
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    out_load   = 1'b0;
    accept     = 1'b0;
    unique case (state)
      gis_pkg::S_IDLE: begin
        in_stall = 1'b0;
        accept   = in_valid;
        if (in_valid) begin
          state_next = mem_re ? gis_pkg::S_READ : gis_pkg::S_DONE;
        end
      end
      gis_pkg::S_READ: begin
        state_next = gis_pkg::S_DONE;
      end
      gis_pkg::S_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = gis_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = gis_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gis_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // size registers and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      init_size <= gis_pkg::INITIAL_SIZE_RST;
      blk_size  <= gis_pkg::BLOCK_SIZE_RST;
      count     <= '0;
      cap       <= CW'(gis_pkg::INITIAL_SIZE_RST);
    end else if (cfg_we) begin
      unique case (gis_pkg::reg_idx_t'(cfg_index))
        gis_pkg::REG_INITIAL_SIZE: begin
          init_size <= cfg_data;
          count     <= '0;
          cap       <= CW'(cfg_data);
        end
        gis_pkg::REG_BLOCK_SIZE: begin
          blk_size <= cfg_data;
        end
        default: begin
          blk_size <= blk_size;
        end
      endcase
    end else if (accept) begin
      count <= count_next;
      cap   <= cap_next;
    end
  end

  // pending result; read data is captured from the memory in the read state
  always_ff @(posedge clk) begin
    if (accept) begin
      pend.status     <= op_status;
      pend.item_out   <= '0;
      pend.item_count <= count_next[gis_pkg::SIZE_W-1:0];
      pend.capacity   <= cap_next[gis_pkg::SIZE_W-1:0];
    end else if (state == gis_pkg::S_READ) begin
      pend.item_out <= mem_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= pend;
    end
  end

endmodule

// ===== design/gis_check.sv =====
// Port-level assertions for the growable indexed stack unit, bound to the top level.
module gis_check (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input gis_pkg::out_t       out_data
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // one item in flight: after an accepted beat the input stalls
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while an item is in flight");

  // status codes stay within the defined set
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status <= gis_pkg::ST_NOT_INIT)
    else $error("result carries an undefined status");

  // failed operations return no item
  a_fail_no_item: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != gis_pkg::ST_OK |-> out_data.item_out == '0)
    else $error("failed operation returned an item");

  // underflow only on an empty store
  a_underflow_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == gis_pkg::ST_UNDERFLOW |-> out_data.item_count == '0)
    else $error("underflow reported with items held");

endmodule

bind growable_indexed_stack_unit gis_check u_gis_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the growable indexed stack unit.
`timescale 1ns / 100ps

module tb_top;

  localparam int DEPTH          = 1024;
  localparam int SHRINK_FACTOR  = 2;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES    = 10;

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            cfg_we    = 1'b0;
  logic [gis_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [gis_pkg::SIZE_W-1:0]      cfg_data  = '0;
  logic                            in_valid  = 1'b0;
  logic                            in_stall;
  gis_pkg::in_t                    in_data   = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  gis_pkg::out_t                   out_data;

  growable_indexed_stack_unit #(.DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the stack state and the size registers
  logic [gis_pkg::SIZE_W-1:0]        sz_init  = gis_pkg::INITIAL_SIZE_RST;
  logic [gis_pkg::SIZE_W-1:0]        sz_block = gis_pkg::BLOCK_SIZE_RST;
  logic [gis_pkg::SIZE_W-1:0]        cnt      = '0;
  logic [gis_pkg::SIZE_W-1:0]        cap      = gis_pkg::INITIAL_SIZE_RST;
  logic signed [gis_pkg::ITEM_W-1:0] shadow_mem [0:DEPTH-1];

  gis_pkg::in_t  pending_ops [$];
  gis_pkg::out_t want_q [$];
  int   errors     = 0;
  int   out_beats  = 0;
  int   tx_wait    = 0;
  int   rx_wait    = 0;
  int   rx_hold    = 0;
  int   rx_draw;
  int   idle_cycles = 0;
  logic tx_burst   = 1'b0;
  logic rx_burst   = 1'b0;
  gis_pkg::out_t want;

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic gis_pkg::out_t apply_op(gis_pkg::in_t it);
    gis_pkg::out_t r;
    int   c;
    int   k;
    int   b;
    int   pos;
    r.status   = gis_pkg::ST_OK;
    r.item_out = '0;
    c = cnt;
    k = cap;
    b = sz_block;
    pos = it.index;
    if (sz_init == 0 && sz_block == 0) begin
      r.status = gis_pkg::ST_NOT_INIT;
    end else begin
      case (it.func)
        gis_pkg::FN_PUSH: begin
          if (c == k) begin
            if (b == 0) r.status = gis_pkg::ST_OVERFLOW;
            else if (k + b > DEPTH) r.status = gis_pkg::ST_NO_ROOM;
            else k = k + b;
          end
          if (r.status == gis_pkg::ST_OK && c >= DEPTH) r.status = gis_pkg::ST_NO_ROOM;
          if (r.status == gis_pkg::ST_OK) begin
            shadow_mem[c] = it.item_value;
            c = c + 1;
          end
        end
        gis_pkg::FN_POP: begin
          if (c == 0) begin
            r.status = gis_pkg::ST_UNDERFLOW;
          end else begin
            // shrink before the pop once enough space lies unused
            if (k > sz_init && c + SHRINK_FACTOR * b <= k) k = k - b;
            r.item_out = shadow_mem[c-1];
            c = c - 1;
          end
        end
        default: begin
          if (pos < 1 || pos > c) r.status = gis_pkg::ST_WRONG_INDEX;
          else if (it.func == gis_pkg::FN_GET) r.item_out = shadow_mem[pos-1];
          else shadow_mem[pos-1] = it.item_value;
        end
      endcase
    end
    cnt = gis_pkg::SIZE_W'(c);
    cap = gis_pkg::SIZE_W'(k);
    r.item_count = gis_pkg::SIZE_W'(c);
    r.capacity   = gis_pkg::SIZE_W'(k);
    return r;
  endfunction

  function automatic gis_pkg::in_t pick_item(int push_pct);
    gis_pkg::in_t it;
    int  hi;
    if ($urandom_range(0, 99) < push_pct) begin
      it.func = gis_pkg::FN_PUSH;
    end else begin
      case ($urandom_range(0, 2))
        0:       it.func = gis_pkg::FN_POP;
        1:       it.func = gis_pkg::FN_GET;
        default: it.func = gis_pkg::FN_SET;
      endcase
    end
    hi = (cnt > 0) ? int'(cnt) : 1;
    case ($urandom_range(0, 9))
      0:       it.index = '0;
      1:       it.index = cnt + gis_pkg::SIZE_W'(1);
      2:       it.index = gis_pkg::SIZE_W'($urandom_range(0, 1024));
      default: it.index = gis_pkg::SIZE_W'($urandom_range(1, hi));
    endcase
    case ($urandom_range(0, 15))
      0:       it.item_value = '0;
      1:       it.item_value = 32'h7fff_ffff;
      2:       it.item_value = 32'h8000_0000;
      default: it.item_value = $urandom;
    endcase
    return it;
  endfunction

  // Sender: offer pending beats, hold while stalled, idle between beats outside bursts
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_wait  <= 0;
    end else begin
      if (in_valid && !in_stall) want_q.push_back(apply_op(in_data));
      if ($urandom_range(0, 39) == 0) tx_burst <= !tx_burst;
      if (in_valid && in_stall) begin
        // hold the stalled beat
      end else if (tx_wait > 0) begin
        in_valid <= 1'b0;
        tx_wait  <= tx_wait - 1;
      end else if (pending_ops.size() > 0) begin
        in_data  <= pending_ops.pop_front();
        in_valid <= 1'b1;
        tx_wait  <= tx_burst ? 0 : $urandom_range(0, 3);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: check each result beat, then stall for a drawn number of cycles
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_wait   <= 0;
      rx_hold   <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        out_beats++;
        if (want_q.size() == 0) begin
          report_mismatch("result beat with nothing outstanding");
        end else begin
          want = want_q.pop_front();
          if (out_data.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      out_data.status, want.status));
          if (out_data.item_out !== want.item_out)
            report_mismatch($sformatf("item_out got %h want %h",
                                      out_data.item_out, want.item_out));
          if (out_data.item_count !== want.item_count)
            report_mismatch($sformatf("item_count got %0d want %0d",
                                      out_data.item_count, want.item_count));
          if (out_data.capacity !== want.capacity)
            report_mismatch($sformatf("capacity got %0d want %0d",
                                      out_data.capacity, want.capacity));
        end
      end
      if ($urandom_range(0, 39) == 0) rx_burst <= !rx_burst;
      if (rx_hold > 0) begin
        out_stall <= 1'b1;
        rx_hold   <= rx_hold - 1;
      end else if (out_valid && !out_stall && out_beats == 40) begin
        // long back-pressure so the input side fills and stalls
        out_stall <= 1'b1;
        rx_hold   <= LONG_HOLD;
      end else if (out_valid && !out_stall) begin
        rx_draw   = rx_burst ? 0 : $urandom_range(0, 3);
        out_stall <= (rx_draw != 0);
        rx_wait   <= (rx_draw == 0) ? 0 : rx_draw - 1;
      end else if (rx_wait > 0) begin
        out_stall <= 1'b1;
        rx_wait   <= rx_wait - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic wait_idle();
    @(negedge clk);
    while (pending_ops.size() != 0 || in_valid || want_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(gis_pkg::reg_idx_t r, int v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= gis_pkg::SIZE_W'(v);
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (r == gis_pkg::REG_INITIAL_SIZE) begin
      sz_init = gis_pkg::SIZE_W'(v);
      cnt     = '0;
      cap     = gis_pkg::SIZE_W'(v);
    end else begin
      sz_block = gis_pkg::SIZE_W'(v);
    end
  endtask

  task automatic set_sizes(int init_v, int blk_v);
    wait_idle();
    write_reg(gis_pkg::REG_BLOCK_SIZE, blk_v);
    write_reg(gis_pkg::REG_INITIAL_SIZE, init_v);
  endtask

  task automatic queue_item(gis_pkg::func_t f, int idx, logic [gis_pkg::ITEM_W-1:0] v);
    gis_pkg::in_t it;
    it.func       = f;
    it.index      = gis_pkg::SIZE_W'(idx);
    it.item_value = v;
    pending_ops.push_back(it);
  endtask

  // Alternate push-heavy and pop-heavy stretches so capacity grows and shrinks
  task automatic run_random(int init_v, int blk_v, int n, int push_hi, int push_lo);
    int k;
    set_sizes(init_v, blk_v);
    for (k = 0; k < n; k++) begin
      while (pending_ops.size() >= 2) @(negedge clk);
      pending_ops.push_back(pick_item(((k / 30) % 2 == 0) ? push_hi : push_lo));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset sizes: empty-store errors, value extremes, bad indexes, set of zero
    queue_item(gis_pkg::FN_POP,  0, 32'h0);
    queue_item(gis_pkg::FN_GET,  1, 32'h0);
    queue_item(gis_pkg::FN_SET,  0, 32'h1234_5678);
    queue_item(gis_pkg::FN_PUSH, 0, 32'h7fff_ffff);
    queue_item(gis_pkg::FN_PUSH, 0, 32'h8000_0000);
    queue_item(gis_pkg::FN_PUSH, 0, 32'hffff_ffff);
    queue_item(gis_pkg::FN_GET,  1, 32'h0);
    queue_item(gis_pkg::FN_GET,  3, 32'h0);
    queue_item(gis_pkg::FN_GET,  0, 32'h0);
    queue_item(gis_pkg::FN_GET,  4, 32'h0);
    queue_item(gis_pkg::FN_SET,  2, 32'h0);
    queue_item(gis_pkg::FN_GET,  2, 32'h0);
    queue_item(gis_pkg::FN_POP,  0, 32'h0);
    queue_item(gis_pkg::FN_POP,  0, 32'h0);
    queue_item(gis_pkg::FN_POP,  1024, 32'hffff_ffff);
    queue_item(gis_pkg::FN_POP,  0, 32'h0);

    // both sizes zero: nothing is initialized
    set_sizes(0, 0);
    queue_item(gis_pkg::FN_PUSH, 0, 32'h5);
    queue_item(gis_pkg::FN_POP,  0, 32'h0);
    queue_item(gis_pkg::FN_GET,  1, 32'h0);
    queue_item(gis_pkg::FN_SET,  1, 32'h5);

    // full store with no growth step
    set_sizes(2, 0);
    queue_item(gis_pkg::FN_PUSH, 0, 32'h11);
    queue_item(gis_pkg::FN_PUSH, 0, 32'h22);
    queue_item(gis_pkg::FN_PUSH, 0, 32'h33);

    // full store whose growth would pass the depth
    set_sizes(2, 1024);
    queue_item(gis_pkg::FN_PUSH, 0, 32'h44);
    queue_item(gis_pkg::FN_PUSH, 0, 32'h55);
    queue_item(gis_pkg::FN_PUSH, 0, 32'h66);

    run_random(16, 16, 150, 80, 20);
    run_random(0, 1, 120, 75, 25);
    run_random(4, 4, 150, 80, 20);
    run_random(3, 0, 80, 70, 30);
    run_random(1, 1024, 50, 60, 40);
    run_random(0, 1024, 40, 70, 30);
    run_random(480, 24, 520, 99, 99);
    run_random(0, 0, 30, 50, 50);
    run_random(1024, 1024, 30, 60, 40);

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (want_q.size() != 0) report_mismatch("results still outstanding at end of run");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/gis_pkg.sv
design/gis_ram.sv
design/growable_indexed_stack_unit.sv
design/gis_check.sv
tb/tb_top.sv
